[rtl/gaussian_window_filter_top_macros.svh]
//------------------------------------------------------------------------------
// Gaussian window filter assertion macros
// Shared property macros for the filter RTL; empty when SYNTH is defined.
//------------------------------------------------------------------------------
`ifndef GAUSSIAN_WINDOW_FILTER_TOP_MACROS_SVH
`define GAUSSIAN_WINDOW_FILTER_TOP_MACROS_SVH

`ifndef SYNTH
// consequent must hold in the same cycle as the antecedent
`define GWF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// consequent must hold in the cycle after the antecedent
`define GWF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GWF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define GWF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/gwf_pkg.sv]
//------------------------------------------------------------------------------
// Gaussian window filter package
// Sizes, codes and beat types shared by the filter modules.
//------------------------------------------------------------------------------
package gwf_pkg;

   // row band geometry (band depth is a power of two)
   localparam int BAND_BITS   = 3;
   localparam int BAND_ROWS   = 1 << BAND_BITS;
   localparam int COL_BITS    = 12;
   localparam int MAX_WIDTH   = 1 << COL_BITS;
   localparam int BAND_DEPTH  = BAND_ROWS * MAX_WIDTH;
   localparam int BAND_ADDR_W = BAND_BITS + COL_BITS;
   localparam int PIX_W       = 16;
   localparam int RGB_W       = 3 * PIX_W;

   // weight table
   localparam int TBL_BITS    = 9;
   localparam int TABLE_DEPTH = 1 << TBL_BITS;
   localparam int WGT_W       = 16;

   // datapath widths
   localparam int POS_W   = 14;
   localparam int DABS_W  = 38;
   localparam int DIST_W  = 22;
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 22;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int SQ_W    = 44;
   localparam int ACC_W   = 43;
   localparam int WS_W    = 26;

   localparam logic [DIST_W-1:0] DIST_SAT = DIST_W'(32 << 16);

   // shared divider
   localparam int DIV_NUM_W = ACC_W;
   localparam int DIV_DEN_W = WS_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_X_SCALE    = 3'd0;
   localparam logic [2:0] REG_Y_SCALE    = 3'd1;
   localparam logic [2:0] REG_INV_RADIUS = 3'd2;
   localparam logic [2:0] REG_X_SEARCH   = 3'd3;
   localparam logic [2:0] REG_Y_SEARCH   = 3'd4;
   localparam logic [2:0] REG_WRAP       = 3'd5;
   localparam logic [2:0] REG_PIC_WIDTH  = 3'd6;
   localparam logic [2:0] REG_PIC_HEIGHT = 3'd7;

   // item kinds
   localparam logic [1:0] KIND_STORE  = 2'd0;
   localparam logic [1:0] KIND_TABLE  = 2'd1;
   localparam logic [1:0] KIND_FILTER = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [11:0]         pixel_row;
      logic [11:0]         pixel_col;
      logic [PIX_W-1:0]    red_in;
      logic [PIX_W-1:0]    green_in;
      logic [PIX_W-1:0]    blue_in;
      logic [TBL_BITS-1:0] weight_addr;
      logic [WGT_W-1:0]    weight_word;
      logic [11:0]         centre_x;
      logic [11:0]         centre_y;
      logic [11:0]         out_col;
      logic [11:0]         out_row;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
      logic [DIV_DEN_W-1:0] rem;
   } div_rsp_type;

endpackage

[rtl/gwf_ram.sv]
//------------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
//------------------------------------------------------------------------------
module gwf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[rtl/gwf_mul.sv]
//------------------------------------------------------------------------------
// Shared multiplier
// Unsigned 24 x 22 multiplier with a registered product.
//------------------------------------------------------------------------------
module gwf_mul (
   input  logic                         clock,
   input  logic [gwf_pkg::MUL_A_W-1:0]  mul_a,
   input  logic [gwf_pkg::MUL_B_W-1:0]  mul_b,
   output logic [gwf_pkg::MUL_P_W-1:0]  mul_p
);

   import gwf_pkg::*;

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   // product lands in the cycle after the operands
   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   assign mul_p   = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[rtl/gwf_div.sv]
//------------------------------------------------------------------------------
// Shared divider
// Restoring divider, one quotient bit per cycle, quotient and remainder out.
//------------------------------------------------------------------------------
module gwf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gwf_pkg::div_req_type  div_req,
   output gwf_pkg::div_rsp_type  div_rsp
);

   import gwf_pkg::*;

   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // one trial subtract per cycle
   always_comb begin
      shifted = {rem_ff, quot_ff[DIV_NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quot_in = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_NUM_W-2:0], fits};
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

[rtl/gaussian_window_filter_top.sv]
//------------------------------------------------------------------------------
// Gaussian window filter top level
// Row band store, weight table and a sequencer that walks the window taps
// through one shared multiplier and one shared divider.
//
//   Channel   Ports                   Direction  Beat
//   req       req_valid/stall/data    in         store, table or filter item
//   rsp       rsp_valid/stall/data    out        filtered RGB pixel
//   csr       psel ... prdata         in/out     register write or read
//
// Store and table items are written as they are accepted. A filter item
// walks every row and tap of its window, but does the arithmetic only for
// rows in the picture and taps used; the shared multiplier (four products
// per row, seven per tap) and the bit-serial divider (one wrap divide and
// three channel divides) carry that arithmetic.
// Reset runs no clearing pass: band and table hold garbage until written.
// A stalled result waits in the output register; the next item is taken.
//------------------------------------------------------------------------------
`include "gaussian_window_filter_top_macros.svh"

module gaussian_window_filter_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  gwf_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output gwf_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gwf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gwf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gwf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   import gwf_pkg::*;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_WRAP    = 5'd1;
   localparam logic [4:0] ST_WRAP_W  = 5'd2;
   localparam logic [4:0] ST_R_CHECK = 5'd3;
   localparam logic [4:0] ST_R_SAVE  = 5'd4;
   localparam logic [4:0] ST_R_NEXT  = 5'd5;
   localparam logic [4:0] ST_T_CHECK = 5'd6;
   localparam logic [4:0] ST_T_IDX   = 5'd7;
   localparam logic [4:0] ST_T_WT    = 5'd8;
   localparam logic [4:0] ST_T_M0    = 5'd9;
   localparam logic [4:0] ST_T_M1    = 5'd10;
   localparam logic [4:0] ST_T_M2    = 5'd11;
   localparam logic [4:0] ST_T_NEXT  = 5'd12;
   localparam logic [4:0] ST_D0      = 5'd13;
   localparam logic [4:0] ST_D1      = 5'd14;
   localparam logic [4:0] ST_D2      = 5'd15;
   localparam logic [4:0] ST_D3      = 5'd16;
   localparam logic [4:0] ST_D4      = 5'd17;
   localparam logic [4:0] ST_SQ      = 5'd18;
   localparam logic [4:0] ST_DIV     = 5'd19;
   localparam logic [4:0] ST_DIV_W   = 5'd20;
   localparam logic [4:0] ST_OUT     = 5'd21;

   // configuration registers
   logic [23:0] x_scale_ff, y_scale_ff, inv_radius_ff;
   logic [3:0]  x_search_ff, y_search_ff;
   logic        wrap_ff;
   logic [12:0] pic_width_ff, pic_height_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   // sequencer state
   logic [4:0]          state_ff, state_in;
   logic [POS_W-1:0]    x_start_ff, x_start_in, x_end_ff, x_end_in;
   logic [POS_W-1:0]    y_ff, y_in, y_end_ff, y_end_in, x_ff, x_in;
   logic [11:0]         ocol_ff, ocol_in, orow_ff, orow_in;
   logic [COL_BITS-1:0] wcol_start_ff, wcol_start_in, wcol_ff, wcol_in;
   logic [DABS_W-1:0]   dabs_ff, dabs_in;
   logic [MUL_P_W-1:0]  lo_ff, lo_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic                dist_row_ff, dist_row_in;
   logic [SQ_W-1:0]     dy2_ff, dy2_in;
   logic [WGT_W-1:0]    wt_ff, wt_in;
   logic [RGB_W-1:0]    pix_ff, pix_in;
   logic [WS_W-1:0]     ws_ff, ws_in;
   logic [ACC_W-1:0]    acc_ff [3];
   logic [ACC_W-1:0]    acc_in [3];
   logic [PIX_W-1:0]    res_ff [3];
   logic [PIX_W-1:0]    res_in [3];
   logic [1:0]          ch_ff, ch_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath helpers
   logic                   req_accept;
   logic [12:0]            w_eff;
   logic                   x_outside, y_outside;
   logic [POS_W-1:0]       pos_sel, pos_abs, mag;
   logic                   pos_neg;
   logic [23:0]            scale_sel;
   logic [11:0]            opos_sel;
   logic [DABS_W-1:0]      opos_term, prod_lo;
   logic [62:0]            full;
   logic [45:0]            dist_raw;
   logic [SQ_W:0]          sum_sq;
   logic [47:0]            q_idx;
   logic [15:0]            idx_raw;
   logic [TBL_BITS-1:0]    idx;
   logic [12:0]            wrap_rem;
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [MUL_P_W-1:0]     mul_p;
   div_req_type            div_req;
   div_rsp_type            div_rsp;
   logic                   band_we, weight_we;
   logic [BAND_ADDR_W-1:0] band_waddr, band_raddr;
   logic [RGB_W-1:0]       band_wdata, band_rdata;
   logic [WGT_W-1:0]       weight_rdata;

   //---------------------------------------------------------------------------
   // configuration port
   //---------------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff    <= 24'h01_0000;
         y_scale_ff    <= 24'h01_0000;
         inv_radius_ff <= 24'h01_0000;
         x_search_ff   <= 4'd1;
         y_search_ff   <= 4'd1;
         wrap_ff       <= 1'b0;
         pic_width_ff  <= 13'd4096;
         pic_height_ff <= 13'd4096;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_X_SCALE:    x_scale_ff    <= pwdata[23:0];
            REG_Y_SCALE:    y_scale_ff    <= pwdata[23:0];
            REG_INV_RADIUS: inv_radius_ff <= pwdata[23:0];
            REG_X_SEARCH:   x_search_ff   <= pwdata[3:0];
            REG_Y_SEARCH:   y_search_ff   <= pwdata[3:0];
            REG_WRAP:       wrap_ff       <= pwdata[0];
            REG_PIC_WIDTH:  pic_width_ff  <= pwdata[12:0];
            REG_PIC_HEIGHT: pic_height_ff <= pwdata[12:0];
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_idx)
         REG_X_SCALE:    prdata = CSR_DATA_W'(x_scale_ff);
         REG_Y_SCALE:    prdata = CSR_DATA_W'(y_scale_ff);
         REG_INV_RADIUS: prdata = CSR_DATA_W'(inv_radius_ff);
         REG_X_SEARCH:   prdata = CSR_DATA_W'(x_search_ff);
         REG_Y_SEARCH:   prdata = CSR_DATA_W'(y_search_ff);
         REG_WRAP:       prdata = CSR_DATA_W'(wrap_ff);
         REG_PIC_WIDTH:  prdata = CSR_DATA_W'(pic_width_ff);
         REG_PIC_HEIGHT: prdata = CSR_DATA_W'(pic_height_ff);
      endcase
   end

   //---------------------------------------------------------------------------
   // storage: row band and weight table, written by store and table beats
   //---------------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign band_we    = req_accept && (req_data.kind == KIND_STORE);
   assign weight_we  = req_accept && (req_data.kind == KIND_TABLE);
   assign band_waddr = {req_data.pixel_row[BAND_BITS-1:0], req_data.pixel_col};
   assign band_wdata = {req_data.red_in, req_data.green_in, req_data.blue_in};
   assign band_raddr = {y_ff[BAND_BITS-1:0], wcol_ff};

   gwf_ram #(
      .WIDTH (RGB_W),
      .DEPTH (BAND_DEPTH)
   ) u_band_ram (
      .clock (clock),
      .we    (band_we),
      .waddr (band_waddr),
      .wdata (band_wdata),
      .raddr (band_raddr),
      .rdata (band_rdata)
   );

   gwf_ram #(
      .WIDTH (WGT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_weight_ram (
      .clock (clock),
      .we    (weight_we),
      .waddr (req_data.weight_addr),
      .wdata (req_data.weight_word),
      .raddr (idx),
      .rdata (weight_rdata)
   );

   //---------------------------------------------------------------------------
   // shared arithmetic
   //---------------------------------------------------------------------------
   gwf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   gwf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   //---------------------------------------------------------------------------
   // window bounds and tap distance helpers
   //---------------------------------------------------------------------------
   always_comb begin
      if (pic_width_ff == 13'd0) begin
         w_eff = 13'd1;
      end else if (pic_width_ff > 13'(MAX_WIDTH)) begin
         w_eff = 13'(MAX_WIDTH);
      end else begin
         w_eff = pic_width_ff;
      end
   end

   assign x_outside = x_ff[POS_W-1] || (x_ff[12:0] >= w_eff);
   assign y_outside = y_ff[POS_W-1] || (y_ff[12:0] >= pic_height_ff);

   // |2p+1| for the selected axis
   assign pos_sel   = dist_row_ff ? y_ff : x_ff;
   assign scale_sel = dist_row_ff ? y_scale_ff : x_scale_ff;
   assign opos_sel  = dist_row_ff ? orow_ff : ocol_ff;
   assign pos_neg   = pos_sel[POS_W-1];
   assign pos_abs   = pos_neg ? (POS_W'(0) - pos_sel) : pos_sel;
   assign mag       = pos_neg ? ({pos_abs[12:0], 1'b0} - POS_W'(1))
                              : {pos_abs[12:0], 1'b1};
   assign opos_term = DABS_W'({opos_sel, 1'b1, 16'h0000});
   assign prod_lo   = mul_p[DABS_W-1:0];

   // |d| * inv_radius, rounded and saturated at 32.0
   assign full     = 63'(lo_ff) + (63'(mul_p[39:0]) << 22) + 63'h1_0000;
   assign dist_raw = full[62:17];

   // table index from dx^2 + dy^2
   assign sum_sq  = {1'b0, mul_p[SQ_W-1:0]} + {1'b0, dy2_ff};
   assign q_idx   = (48'(sum_sq) << 3) + (48'(sum_sq) << 1) + 48'h0000_8000_0000;
   assign idx_raw = q_idx[47:32];
   assign idx     = (idx_raw > 16'(TABLE_DEPTH - 1)) ? TBL_BITS'(TABLE_DEPTH - 1)
                                                     : idx_raw[TBL_BITS-1:0];

   assign wrap_rem = div_rsp.rem[12:0];

   //---------------------------------------------------------------------------
   // sequencer
   //---------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      x_start_in    = x_start_ff;
      x_end_in      = x_end_ff;
      y_in          = y_ff;
      y_end_in      = y_end_ff;
      x_in          = x_ff;
      ocol_in       = ocol_ff;
      orow_in       = orow_ff;
      wcol_start_in = wcol_start_ff;
      wcol_in       = wcol_ff;
      dabs_in       = dabs_ff;
      lo_in         = lo_ff;
      dist_in       = dist_ff;
      dist_row_in   = dist_row_ff;
      dy2_in        = dy2_ff;
      wt_in         = wt_ff;
      pix_in        = pix_ff;
      ws_in         = ws_ff;
      acc_in        = acc_ff;
      res_in        = res_ff;
      ch_in         = ch_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mul_a         = '0;
      mul_b         = '0;
      div_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.kind == KIND_FILTER)) begin
               x_start_in = {2'b00, req_data.centre_x} - POS_W'(x_search_ff);
               x_end_in   = {2'b00, req_data.centre_x} + POS_W'(x_search_ff);
               y_in       = {2'b00, req_data.centre_y} - POS_W'(y_search_ff);
               y_end_in   = {2'b00, req_data.centre_y} + POS_W'(y_search_ff);
               ocol_in    = req_data.out_col;
               orow_in    = req_data.out_row;
               ws_in      = WS_W'(1);
               acc_in[0]  = '0;
               acc_in[1]  = '0;
               acc_in[2]  = '0;
               state_in   = ST_WRAP;
            end
         end
         // first window column modulo the width
         ST_WRAP: begin
            div_req.start = 1'b1;
            div_req.num   = x_start_ff[POS_W-1] ? DIV_NUM_W'(POS_W'(0) - x_start_ff)
                                                : DIV_NUM_W'(x_start_ff);
            div_req.den   = DIV_DEN_W'(w_eff);
            state_in      = ST_WRAP_W;
         end
         ST_WRAP_W: begin
            if (div_rsp.done) begin
               if (x_start_ff[POS_W-1] && (wrap_rem != 13'd0)) begin
                  wcol_start_in = COL_BITS'(w_eff - wrap_rem);
               end else if (x_start_ff[POS_W-1]) begin
                  wcol_start_in = '0;
               end else begin
                  wcol_start_in = COL_BITS'(wrap_rem);
               end
               state_in = ST_R_CHECK;
            end
         end
         ST_R_CHECK: begin
            if (y_outside) begin
               state_in = ST_R_NEXT;
            end else begin
               dist_row_in = 1'b1;
               state_in    = ST_D0;
            end
         end
         // tap distance: scale*(2p+1), |d|, two partial products, round and saturate
         ST_D0: begin
            mul_a    = scale_sel;
            mul_b    = MUL_B_W'(mag);
            state_in = ST_D1;
         end
         ST_D1: begin
            if (pos_neg) begin
               dabs_in = prod_lo + opos_term;
            end else if (prod_lo >= opos_term) begin
               dabs_in = prod_lo - opos_term;
            end else begin
               dabs_in = opos_term - prod_lo;
            end
            state_in = ST_D2;
         end
         ST_D2: begin
            mul_a    = inv_radius_ff;
            mul_b    = dabs_ff[21:0];
            state_in = ST_D3;
         end
         ST_D3: begin
            lo_in    = mul_p;
            mul_a    = inv_radius_ff;
            mul_b    = MUL_B_W'(dabs_ff[DABS_W-1:22]);
            state_in = ST_D4;
         end
         ST_D4: begin
            dist_in  = (dist_raw > 46'(DIST_SAT)) ? DIST_SAT : dist_raw[DIST_W-1:0];
            state_in = ST_SQ;
         end
         ST_SQ: begin
            mul_a    = MUL_A_W'(dist_ff);
            mul_b    = dist_ff;
            state_in = dist_row_ff ? ST_R_SAVE : ST_T_IDX;
         end
         ST_R_SAVE: begin
            dy2_in   = mul_p[SQ_W-1:0];
            x_in     = x_start_ff;
            wcol_in  = wcol_start_ff;
            state_in = ST_T_CHECK;
         end
         ST_T_CHECK: begin
            if (x_outside && !wrap_ff) begin
               state_in = ST_T_NEXT;
            end else begin
               dist_row_in = 1'b0;
               state_in    = ST_D0;
            end
         end
         // weight and pixel reads go out here
         ST_T_IDX: begin
            state_in = ST_T_WT;
         end
         ST_T_WT: begin
            wt_in    = weight_rdata;
            pix_in   = band_rdata;
            ws_in    = ws_ff + WS_W'(weight_rdata);
            mul_a    = MUL_A_W'(weight_rdata);
            mul_b    = MUL_B_W'(band_rdata[RGB_W-1:2*PIX_W]);
            state_in = ST_T_M0;
         end
         ST_T_M0: begin
            acc_in[0] = acc_ff[0] + ACC_W'(mul_p[31:0]);
            mul_a     = MUL_A_W'(wt_ff);
            mul_b     = MUL_B_W'(pix_ff[2*PIX_W-1:PIX_W]);
            state_in  = ST_T_M1;
         end
         ST_T_M1: begin
            acc_in[1] = acc_ff[1] + ACC_W'(mul_p[31:0]);
            mul_a     = MUL_A_W'(wt_ff);
            mul_b     = MUL_B_W'(pix_ff[PIX_W-1:0]);
            state_in  = ST_T_M2;
         end
         ST_T_M2: begin
            acc_in[2] = acc_ff[2] + ACC_W'(mul_p[31:0]);
            state_in  = ST_T_NEXT;
         end
         ST_T_NEXT: begin
            if (x_ff == x_end_ff) begin
               state_in = ST_R_NEXT;
            end else begin
               x_in     = x_ff + POS_W'(1);
               wcol_in  = (({1'b0, wcol_ff} + 13'd1) == w_eff) ? '0
                                                              : wcol_ff + COL_BITS'(1);
               state_in = ST_T_CHECK;
            end
         end
         ST_R_NEXT: begin
            if (y_ff == y_end_ff) begin
               ch_in    = 2'd0;
               state_in = ST_DIV;
            end else begin
               y_in     = y_ff + POS_W'(1);
               state_in = ST_R_CHECK;
            end
         end
         // (acc + ws/2) / ws per channel
         ST_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = acc_ff[ch_ff] + ACC_W'(ws_ff >> 1);
            div_req.den   = ws_ff;
            state_in      = ST_DIV_W;
         end
         ST_DIV_W: begin
            if (div_rsp.done) begin
               res_in[ch_ff] = (div_rsp.quot > DIV_NUM_W'(16'hFFFF)) ? 16'hFFFF
                                                                   : div_rsp.quot[15:0];
               if (ch_ff == 2'd2) begin
                  state_in = ST_OUT;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.red_out   = res_ff[0];
               rsp_in.green_out = res_ff[1];
               rsp_in.blue_out  = res_ff[2];
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dist_row_ff  <= 1'b0;
         ch_ff        <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dist_row_ff  <= dist_row_in;
         ch_ff        <= ch_in;
      end
      x_start_ff    <= x_start_in;
      x_end_ff      <= x_end_in;
      y_ff          <= y_in;
      y_end_ff      <= y_end_in;
      x_ff          <= x_in;
      ocol_ff       <= ocol_in;
      orow_ff       <= orow_in;
      wcol_start_ff <= wcol_start_in;
      wcol_ff       <= wcol_in;
      dabs_ff       <= dabs_in;
      lo_ff         <= lo_in;
      dist_ff       <= dist_in;
      dy2_ff        <= dy2_in;
      wt_ff         <= wt_in;
      pix_ff        <= pix_in;
      ws_ff         <= ws_in;
      acc_ff        <= acc_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   //---------------------------------------------------------------------------
   // assertions
   //---------------------------------------------------------------------------
   `GWF_ASSERT_SAME(a_wcol_sync, clock, reset, (state_ff == ST_T_CHECK) && !x_outside, wcol_ff == x_ff[COL_BITS-1:0], "wrapped column out of step with window column")
   `GWF_ASSERT_SAME(a_div_free, clock, reset, div_req.start, !div_rsp.busy, "divider started while busy")
   `GWF_ASSERT_SAME(a_dist_sat, clock, reset, state_ff == ST_SQ, dist_ff <= DIST_SAT, "tap distance above saturation")
   `GWF_ASSERT_NEXT(a_rsp_load, clock, reset, (state_ff == ST_OUT) && !(rsp_valid_ff && rsp_stall), rsp_valid_ff && (state_ff == ST_IDLE), "result not loaded")

endmodule
